// ===== design/owbm_pkg.sv =====
// Shared types and timing constants for the one-wire bus master.
`default_nettype none

package owbm_pkg;

	// Command carried with each tick
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_RESET = 2'd1,
		KIND_WRITE = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	// Bus sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_RSTLOW  = 3'd1,
		PH_RSTPRES = 3'd2,
		PH_RSTREL  = 3'd3,
		PH_BITLOW  = 3'd4,
		PH_BITHIGH = 3'd5,
		PH_RDSAMP  = 3'd6,
		PH_RDREC   = 3'd7
	} phase_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_TICKS_PER_US   = 2'd0,
		CFG_RESET_LOW_US   = 2'd1,
		CFG_READ_SAMPLE_US = 2'd2
	} cfg_idx_t;

	// Configuration reset values
	localparam logic [7:0] TICKS_PER_US_RST   = 8'd16;
	localparam logic [9:0] RESET_LOW_US_RST   = 10'd500;
	localparam logic [3:0] READ_SAMPLE_US_RST = 4'd10;

	// Bus timing in microseconds
	localparam logic [9:0] US_PRES_WAIT  = 10'd60;
	localparam logic [9:0] US_PRES_CHECK = 10'd250;
	localparam logic [9:0] US_READ_LOW   = 10'd2;
	localparam logic [9:0] US_W1_LOW     = 10'd4;
	localparam logic [9:0] US_W1_HIGH    = 10'd76;
	localparam logic [9:0] US_W0_LOW     = 10'd80;
	localparam logic [9:0] US_W0_HIGH    = 10'd5;
	localparam logic [9:0] US_READ_REC   = 10'd60;
	localparam logic [9:0] US_MIN        = 10'd1;

	// One result item, drive_low in the lowest bit
	typedef struct packed {
		logic       rejected;
		logic [7:0] read_data;
		logic       presence;
		logic       done_res;
		logic       busy_res;
		logic       drive_low;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

`default_nettype wire

// ===== design/one_wire_bus_master.sv =====
// One-wire bus master: tick-paced reset, byte write and byte read sequencer.
`default_nettype none

// Every input item is one tick of the bus time base, carrying the sampled line level and an
// optional command (reset, write byte, read byte); a command is taken only while idle and is
// flagged as rejected otherwise. The block takes one item per clock cycle while the skid stage
// is empty and returns exactly one result item per input item, formed in a single pass over the
// sequencer state (an 8-bit prescale compare and a 10-bit microsecond compare between the state
// registers and the output register). A one-entry skid stage behind the output register keeps
// input flowing for one more item while the output side stalls. Bus timing follows the
// configuration registers: ticks_per_us (0 acts as 1), reset_low_us and read_sample_us (0 acts as
// 1 us). The user writes configuration only while the master is idle; the block does not check.
module one_wire_bus_master (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [8] line_level, rest zero
	input  wire logic [1:0]  s_tuser,   // [1:0] kind
	// Result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [0] drive_low, [1] busy_res, [2] done_res, [3] presence, [11:4] read_data,
	// [12] rejected, rest zero
	output logic [15:0]      m_tdata,
	// Configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [9:0]  cfg_data
);
	import owbm_pkg::*;

	// Configuration
	logic [7:0] ticks_q;
	logic [9:0] rst_low_q;
	logic [3:0] rd_samp_q;

	// Sequencer state
	phase_t     phase_q,    phase_n;
	logic [9:0] us_q,       us_n;
	logic [7:0] prescale_q, prescale_n;
	logic [2:0] bit_q,      bit_n;
	logic [7:0] shift_q,    shift_n;
	logic       pres_q,     pres_n;
	kind_t      op_q,       op_n;

	// Output register and skid
	logic       out_vld_q;
	res_t       out_q;
	logic       skid_vld_q;
	res_t       skid_q;

	// Combinational pass
	res_t       res;
	kind_t      kind;
	logic [7:0] data_byte;
	logic       line_level;
	logic       acc;
	logic [7:0] tpu;
	logic [7:0] pre_inc;
	logic [9:0] us_inc;
	logic [9:0] len;
	logic       cur_bit;

	assign kind       = kind_t'(s_tuser);
	assign data_byte  = s_tdata[7:0];
	assign line_level = s_tdata[8];

	assign s_tready  = !skid_vld_q;
	assign acc       = s_tvalid && s_tready;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = {{(16 - RES_W){1'b0}}, out_q};
	assign cfg_ready = 1'b1;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q   <= TICKS_PER_US_RST;
			rst_low_q <= RESET_LOW_US_RST;
			rd_samp_q <= READ_SAMPLE_US_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TICKS_PER_US:   ticks_q   <= cfg_data[7:0];
				CFG_RESET_LOW_US:   rst_low_q <= cfg_data;
				CFG_READ_SAMPLE_US: rd_samp_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Advance the sequencer by one tick and form the result
	always_comb begin
		phase_n    = phase_q;
		us_n       = us_q;
		prescale_n = prescale_q;
		bit_n      = bit_q;
		shift_n    = shift_q;
		pres_n     = pres_q;
		op_n       = op_q;
		res        = '0;

		tpu     = (ticks_q == 8'd0) ? 8'd1 : ticks_q;
		pre_inc = prescale_q + 8'd1;
		us_inc  = us_q + 10'd1;
		cur_bit = shift_q[bit_q];

		// Length of the current phase
		unique case (phase_q)
			PH_RSTLOW:  len = rst_low_q;
			PH_RSTPRES: len = US_PRES_WAIT;
			PH_RSTREL:  len = US_PRES_CHECK;
			PH_BITLOW:  len = (op_q == KIND_READ) ? US_READ_LOW :
			                  (cur_bit ? US_W1_LOW : US_W0_LOW);
			PH_BITHIGH: len = cur_bit ? US_W1_HIGH : US_W0_HIGH;
			PH_RDSAMP:  len = {6'd0, rd_samp_q};
			PH_RDREC:   len = US_READ_REC;
			PH_IDLE:    len = US_MIN;
		endcase
		if (len == 10'd0) begin
			len = US_MIN;
		end

		if (phase_q == PH_IDLE) begin
			// Start a command
			if (kind != KIND_TICK) begin
				op_n       = kind;
				us_n       = 10'd0;
				prescale_n = 8'd0;
				bit_n      = 3'd0;
				if (kind == KIND_RESET) begin
					pres_n  = 1'b0;
					phase_n = PH_RSTLOW;
				end else begin
					shift_n = (kind == KIND_WRITE) ? data_byte : 8'd0;
					phase_n = PH_BITLOW;
				end
			end
		end else begin
			res.rejected = (kind != KIND_TICK);
			prescale_n   = pre_inc;
			if (pre_inc >= tpu) begin
				prescale_n = 8'd0;
				us_n       = us_inc;
				if (us_inc >= len) begin
					// End of phase
					us_n = 10'd0;
					unique case (phase_q)
						PH_RSTLOW: phase_n = PH_RSTPRES;
						PH_RSTPRES: begin
							pres_n  = !line_level;
							phase_n = PH_RSTREL;
						end
						PH_RSTREL: begin
							pres_n       = pres_q & line_level;
							phase_n      = PH_IDLE;
							res.done_res = 1'b1;
						end
						PH_BITLOW: phase_n = (op_q == KIND_READ) ? PH_RDSAMP : PH_BITHIGH;
						PH_RDSAMP: begin
							shift_n = shift_q | (8'(line_level) << bit_q);
							phase_n = PH_RDREC;
						end
						PH_BITHIGH, PH_RDREC: begin
							if (bit_q == 3'd7) begin
								phase_n      = PH_IDLE;
								res.done_res = 1'b1;
							end else begin
								bit_n   = bit_q + 3'd1;
								phase_n = PH_BITLOW;
							end
						end
						PH_IDLE: phase_n = PH_IDLE;
					endcase
					if (res.done_res) begin
						res.presence  = (op_q == KIND_RESET) ? pres_n : 1'b0;
						res.read_data = (op_q == KIND_READ) ? shift_n : 8'd0;
					end
				end
			end
		end

		res.drive_low = (phase_n == PH_RSTLOW) || (phase_n == PH_BITLOW);
		res.busy_res  = (phase_n != PH_IDLE);
	end

	// Hold the sequencer state, advance on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			us_q       <= 10'd0;
			prescale_q <= 8'd0;
			bit_q      <= 3'd0;
			shift_q    <= 8'd0;
			pres_q     <= 1'b0;
			op_q       <= KIND_TICK;
		end else if (acc) begin
			phase_q    <= phase_n;
			us_q       <= us_n;
			prescale_q <= prescale_n;
			bit_q      <= bit_n;
			shift_q    <= shift_n;
			pres_q     <= pres_n;
			op_q       <= op_n;
		end
	end

	// Output register and skid valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			out_vld_q  <= skid_vld_q || acc;
			skid_vld_q <= 1'b0;
		end else if (acc) begin
			skid_vld_q <= 1'b1;
		end
	end

	// Output register and skid payload
	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (acc) begin
			skid_q <= res;
		end
	end

	// A completed operation leaves the sequencer idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && res.done_res) |=> (phase_q == PH_IDLE))
		else $error("sequencer not idle after completion");

	// Commands are only rejected while an operation runs
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && res.rejected) |-> (phase_q != PH_IDLE))
		else $error("command rejected while idle");

	// The skid stage only fills behind a held output
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds an item with an empty output register");

	// A stalled output with a pending item fills the skid
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready && acc) |=> skid_vld_q)
		else $error("item lost under output stall");

endmodule

`default_nettype wire
